/* src/m3ma_pkg.sv */
// shared constants and register codes for the median-of-three moving-average filter
`default_nettype none

package m3ma_pkg;

    // default sizes
    localparam int WINDOW_MAX_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // fixed port widths
    localparam int PORT_W     = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ENABLE = 1'b0,
        REG_WINDOW_LENGTH = 1'b1
    } t_cfg_reg;

    // configuration reset values
    localparam logic                  FILTER_ENABLE_RST = 1'b1;
    localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RST = 5'd16;

endpackage

`default_nettype wire

/* src/m3ma_serial_div.sv */
// restoring divider that retires one quotient bit per cycle
`default_nettype none

module m3ma_serial_div #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_acc;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_den;

    logic [DIVISOR_W:0]    w_rem_sh;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fits;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_rem_sh = {r_rem, r_acc[DIVIDEND_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_fits   = (w_rem_sh >= {1'b0, r_den});
    end

    // control: busy until every dividend bit is retired, then a done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= w_diff[DIVISOR_W-1:0];
            end else begin
                r_rem <= w_rem_sh[DIVISOR_W-1:0];
            end
            r_acc <= {r_acc[DIVIDEND_W-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_acc;

endmodule

`default_nettype wire

/* src/median3_moving_average_filter.sv */
// Median-of-three moving-average filter. Each request carries three ADC samples.
// With filtering enabled the median of the three enters a window of the last
// n medians (n = effective window length; entries zero at reset) and the result is the
// truncated mean of that window; with filtering disabled the first sample is
// returned and the window is untouched. One request is worked on at a time. A
// filtered request passes through the serial accumulator, one window entry per
// cycle, then the restoring divider, one sum bit per cycle; the quotient is
// captured and then loaded into the output register. A pass-through result is
// captured at acceptance and then loaded into the output register. The next
// request can be taken once the result is in the output register; a held
// result stalls the input for as long as it waits.
`default_nettype none

module median3_moving_average_filter #(
    parameter int WINDOW_MAX  = m3ma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = m3ma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [m3ma_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [m3ma_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [m3ma_pkg::PORT_W-1:0]     i_sample_first,
    input  wire logic [m3ma_pkg::PORT_W-1:0]     i_sample_second,
    input  wire logic [m3ma_pkg::PORT_W-1:0]     i_sample_third,
    // result
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [m3ma_pkg::PORT_W-1:0]          o_filtered_value
);

    import m3ma_pkg::*;

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = SAMPLE_BITS + LEN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_WAIT
    } t_state;

    t_state                  r_state;
    logic                    r_filter_enable;
    logic [CFG_DATA_W-1:0]   r_window_length;
    logic [SAMPLE_BITS-1:0]  r_win [WINDOW_MAX];
    logic [LEN_W-1:0]        r_len;
    logic [IDX_W-1:0]        r_idx;
    logic [SUM_W-1:0]        r_sum;
    logic [PORT_W-1:0]       r_result;
    logic                    r_out_valid;
    logic [PORT_W-1:0]       r_out_data;

    logic                    w_accept;
    logic [SAMPLE_BITS-1:0]  w_s0;
    logic [SAMPLE_BITS-1:0]  w_s1;
    logic [SAMPLE_BITS-1:0]  w_s2;
    logic [SAMPLE_BITS-1:0]  w_lo;
    logic [SAMPLE_BITS-1:0]  w_hi;
    logic [SAMPLE_BITS-1:0]  w_med;
    logic [LEN_W-1:0]        w_eff_len;
    logic [SAMPLE_BITS-1:0]  w_shift_src [WINDOW_MAX];
    logic [SUM_W-1:0]        n_sum;
    logic                    w_last;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_quotient;
    logic                    w_out_free;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // samples trimmed to the converter width
    assign w_s0 = i_sample_first[SAMPLE_BITS-1:0];
    assign w_s1 = i_sample_second[SAMPLE_BITS-1:0];
    assign w_s2 = i_sample_third[SAMPLE_BITS-1:0];

    // median of three
    always_comb begin
        w_lo = (w_s0 > w_s1) ? w_s1 : w_s0;
        w_hi = (w_s0 > w_s1) ? w_s0 : w_s1;
        if (w_s2 > w_hi) begin
            w_med = w_hi;
        end else if (w_s2 > w_lo) begin
            w_med = w_s2;
        end else begin
            w_med = w_lo;
        end
    end

    // window length clamped to 1..WINDOW_MAX
    always_comb begin
        if (r_window_length == '0) begin
            w_eff_len = LEN_W'(1);
        end else if (r_window_length > CFG_DATA_W'(WINDOW_MAX)) begin
            w_eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            w_eff_len = LEN_W'(r_window_length);
        end
    end

    // neighbor taps of the window shift line
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_tap
        if (g < WINDOW_MAX - 1) begin : g_mid
            assign w_shift_src[g] = r_win[g + 1];
        end else begin : g_top
            assign w_shift_src[g] = w_med;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= FILTER_ENABLE_RST;
            r_window_length <= WINDOW_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_FILTER_ENABLE: r_filter_enable <= i_cfg_data[0];
                REG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // median window: lower entries of the active window shift down, median enters on top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_accept && r_filter_enable) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                if (i + 1 < int'(w_eff_len)) begin
                    r_win[i] <= w_shift_src[i];
                end else if (i + 1 == int'(w_eff_len)) begin
                    r_win[i] <= w_med;
                end
            end
        end
    end

    // serial accumulator, one window entry per cycle
    assign n_sum       = r_sum + SUM_W'(r_win[r_idx]);
    assign w_last      = (LEN_W'(r_idx) + LEN_W'(1)) == r_len;
    assign w_div_start = (r_state == S_SUM) && w_last;

    m3ma_serial_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_len),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            // output register empties unless the wait state reloads it
            if (r_out_valid && i_ready && r_state != S_WAIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_len <= w_eff_len;
                        r_idx <= '0;
                        r_sum <= '0;
                        if (r_filter_enable) begin
                            r_state <= S_SUM;
                        end else begin
                            r_result <= PORT_W'(w_s0);
                            r_state  <= S_WAIT;
                        end
                    end
                end
                S_SUM: begin
                    r_sum <= n_sum;
                    r_idx <= r_idx + IDX_W'(1);
                    if (w_last) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_result <= PORT_W'(w_quotient);
                        r_state  <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_result;
                        r_state     <= S_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_filtered_value = r_out_data;

    // assertions
    a_one_request_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("request accepted while another is in flight");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM || r_state == S_DIV) |->
            (r_len >= LEN_W'(1) && r_len <= LEN_W'(WINDOW_MAX)))
        else $error("window length out of range during work");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide phase");

    a_result_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_WAIT)
        else $error("result loaded without a finished request");

endmodule

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for the median-of-three moving-average filter
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import m3ma_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 148;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 40;
    localparam int SAMPLE_MAX    = (1 << PORT_W) - 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [PORT_W-1:0]     i_sample_first;
    logic [PORT_W-1:0]     i_sample_second;
    logic [PORT_W-1:0]     i_sample_third;
    logic                  o_valid;
    logic                  i_ready;
    logic [PORT_W-1:0]     o_filtered_value;

    median3_moving_average_filter u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_first   (i_sample_first),
        .i_sample_second  (i_sample_second),
        .i_sample_third   (i_sample_third),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_filtered_value (o_filtered_value)
    );

    // directed request table; want is typed in only where typed is set
    typedef struct {
        bit                    en;
        logic [CFG_DATA_W-1:0] len;
        logic [PORT_W-1:0]     a;
        logic [PORT_W-1:0]     b;
        logic [PORT_W-1:0]     c;
        bit                    typed;
        logic [PORT_W-1:0]     want;
    } dir_row_t;

    dir_row_t dir_rows [0:21] = '{
        // defaults right after reset, window all zero
        '{1'b1, 5'd16, 12'd4095, 12'd4095, 12'd4095, 1'b1, 12'd255},
        '{1'b1, 5'd16, 12'd0,    12'd0,    12'd0,    1'b1, 12'd255},
        '{1'b1, 5'd16, 12'hAAA,  12'h555,  12'hFFF,  1'b0, 12'd0},
        // every ordering of three distinct samples
        '{1'b1, 5'd16, 12'd100,  12'd2000, 12'd4000, 1'b0, 12'd0},
        '{1'b1, 5'd16, 12'd100,  12'd4000, 12'd2000, 1'b0, 12'd0},
        '{1'b1, 5'd16, 12'd2000, 12'd100,  12'd4000, 1'b0, 12'd0},
        '{1'b1, 5'd16, 12'd2000, 12'd4000, 12'd100,  1'b0, 12'd0},
        '{1'b1, 5'd16, 12'd4000, 12'd100,  12'd2000, 1'b0, 12'd0},
        '{1'b1, 5'd16, 12'd4000, 12'd2000, 12'd100,  1'b0, 12'd0},
        // equal samples in each position
        '{1'b1, 5'd16, 12'd5,    12'd5,    12'd9,    1'b0, 12'd0},
        '{1'b1, 5'd16, 12'd9,    12'd5,    12'd5,    1'b0, 12'd0},
        '{1'b1, 5'd16, 12'd5,    12'd9,    12'd5,    1'b0, 12'd0},
        // window of one returns the median
        '{1'b1, 5'd1,  12'd100,  12'd200,  12'd300,  1'b1, 12'd200},
        '{1'b1, 5'd1,  12'd4095, 12'd0,    12'd4095, 1'b1, 12'd4095},
        '{1'b1, 5'd1,  12'd0,    12'd4095, 12'd0,    1'b1, 12'd0},
        // zero length acts as one
        '{1'b1, 5'd0,  12'd7,    12'd3,    12'd5,    1'b1, 12'd5},
        '{1'b1, 5'd0,  12'd0,    12'd0,    12'd4095, 1'b1, 12'd0},
        // oversized length saturates, stale upper entries come back
        '{1'b1, 5'd31, 12'd4095, 12'd4095, 12'd0,    1'b0, 12'd0},
        '{1'b1, 5'd31, 12'd1,    12'd1,    12'd1,    1'b0, 12'd0},
        // pass-through of the first sample
        '{1'b0, 5'd31, 12'd4095, 12'd0,    12'd0,    1'b1, 12'd4095},
        '{1'b0, 5'd31, 12'd0,    12'd4095, 12'd4095, 1'b1, 12'd0},
        '{1'b0, 5'd31, 12'h555,  12'd1,    12'd2,    1'b1, 12'h555}
    };

    // predictor state and its copy of the registers
    bit                    filt_en = FILTER_ENABLE_RST;
    logic [CFG_DATA_W-1:0] win_len = WINDOW_LENGTH_RST;
    logic [PORT_W-1:0]     median_win [WINDOW_MAX_DEF] = '{default: '0};

    logic [PORT_W-1:0] filtered_q [$];
    logic [PORT_W-1:0] want_value;
    int                mismatch_cnt = 0;
    int                results_cnt  = 0;
    int                stall_cycles = 0;
    bit                send_idle    = 1'b0;
    bit                recv_idle    = 1'b0;
    bit                hold_done    = 1'b0;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // median into the window, then truncated window mean; raw first sample when off
    function automatic logic [PORT_W-1:0] predict_filtered(input logic [PORT_W-1:0] a,
                                                           input logic [PORT_W-1:0] b,
                                                           input logic [PORT_W-1:0] c);
        logic [PORT_W-1:0] lo;
        logic [PORT_W-1:0] hi;
        logic [PORT_W-1:0] med;
        int                n;
        int                total;
        if (!filt_en) begin
            return a;
        end
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        med = (c < hi) ? c : hi;
        med = (med > lo) ? med : lo;
        n = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(win_len));
        for (int i = 0; i < n - 1; i++) begin
            median_win[i] = median_win[i + 1];
        end
        median_win[n - 1] = med;
        total = 0;
        for (int i = 0; i < n; i++) begin
            total += median_win[i];
        end
        return PORT_W'(total / n);
    endfunction

    // offer one request, hold it until taken, then record what should come back
    task automatic send_request(input logic [PORT_W-1:0] a, input logic [PORT_W-1:0] b,
                                input logic [PORT_W-1:0] c, input bit typed,
                                input logic [PORT_W-1:0] want);
        int                gap;
        logic [PORT_W-1:0] model_val;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample_first  <= a;
        i_sample_second <= b;
        i_sample_third  <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        model_val = predict_filtered(a, b, c);
        filtered_q.push_back(typed ? want : model_val);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        i_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register writes only once the block has gone idle
    task automatic set_config(input bit en, input logic [CFG_DATA_W-1:0] len);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FILTER_ENABLE;
        i_cfg_data <= CFG_DATA_W'(en);
        @(posedge i_clk);
        filt_en    = en;
        i_cfg_idx  <= REG_WINDOW_LENGTH;
        i_cfg_data <= len;
        @(posedge i_clk);
        win_len    = len;
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [PORT_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PORT_W'(SAMPLE_MAX);
            default: return PORT_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    // main sequence: reset, directed table, random phases, end of run
    initial begin
        bit                    en;
        logic [CFG_DATA_W-1:0] len;
        logic [PORT_W-1:0]     a;
        logic [PORT_W-1:0]     b;
        logic [PORT_W-1:0]     c;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_FILTER_ENABLE;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_sample_first  <= '0;
        i_sample_second <= '0;
        i_sample_third  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        send_idle = 1'b1;
        recv_idle = 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].en != filt_en || dir_rows[i].len != win_len) begin
                set_config(dir_rows[i].en, dir_rows[i].len);
            end
            send_request(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
                         dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, extremes of the registers first
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin en = 1'b1; len = 5'd16; end
                1: begin en = 1'b1; len = 5'd1; end
                2: begin en = 1'b1; len = 5'd0; end
                3: begin en = 1'b1; len = 5'd31; end
                4: begin en = 1'b0; len = CFG_DATA_W'($urandom_range(0, 31)); end
                default: begin
                    en  = ($urandom_range(0, 5) != 0);
                    len = CFG_DATA_W'($urandom_range(0, 31));
                end
            endcase
            set_config(en, len);
            send_idle = (p == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
            recv_idle = (p == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                a = pick_sample();
                b = pick_sample();
                c = pick_sample();
                // force ties now and then
                case ($urandom_range(0, 11))
                    0: b = a;
                    1: c = a;
                    2: c = b;
                    3: begin b = a; c = a; end
                    default: ;
                endcase
                send_request(a, b, c, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (filtered_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never came", filtered_q.size()));
        end
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // result side: random stalls, plus one long hold so the block backs up
    initial begin
        int w;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!hold_done && results_cnt >= HOLD_AFTER) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                w = recv_idle ? $urandom_range(0, 10) : 0;
                if (w > 0) begin
                    i_ready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // compare each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_cnt++;
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", o_filtered_value));
            end else begin
                want_value = filtered_q.pop_front();
                if (o_filtered_value !== want_value) begin
                    report_mismatch($sformatf("filtered_value got %0d expected %0d",
                                              o_filtered_value, want_value));
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
